[src/emoc_pkg.sv]
// ----------------------------------------------------------------------------
// emoc_pkg
// Shared types and constants for the extent map with overwrite and coalescing.
// ----------------------------------------------------------------------------
package emoc_pkg;

    localparam int DEF_MAX_EXTENTS = 32;
    localparam int DEF_OFFSET_BITS = 48;
    localparam int ID_W            = 16;
    localparam int CNT_OUT_W       = 6;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_TRUNC = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        IT_OLD   = 2'd0,
        IT_LEFT  = 2'd1,
        IT_NEW   = 2'd2,
        IT_RIGHT = 2'd3
    } t_item;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DISP = 11'b000_0000_0010,
        S_ARD  = 11'b000_0000_0100,
        S_AEV  = 11'b000_0000_1000,
        S_AFIN = 11'b000_0001_0000,
        S_ACOM = 11'b000_0010_0000,
        S_OUT  = 11'b000_0100_0000,
        S_TRD  = 11'b000_1000_0000,
        S_TEV  = 11'b001_0000_0000,
        S_RRD  = 11'b010_0000_0000,
        S_REV  = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic  latch;
        logic  rd_cur;
        logic  rd_top;
        logic  i_inc;
        logic  push;
        t_item item;
        logic  flush;
        logic  commit;
        logic  t_clear;
        logic  t_dec;
        logic  t_trim;
        logic  t_setmax;
        logic  t_zeromax;
        logic  take;
        logic  emit_simple;
        logic  emit_chunk;
        logic  chunk_last;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic rev;
        logic size_zero;
        logic rlen_zero;
        logic i_eq_used;
        logic used_zero;
        logic found;
        logic o_lt_new;
        logic o_gt_new;
        logic o_s_lt_n;
        logic o_e_gt_n;
        logic t_e_ge;
        logic t_s_ge;
        logic r_e_lt_rs;
        logic r_s_gt_rend;
    } t_sts;

endpackage

[src/emoc_ram.sv]
// ----------------------------------------------------------------------------
// emoc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module emoc_ram #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/emoc_ctrl.sv]
// ----------------------------------------------------------------------------
// emoc_ctrl
// Request sequencer: walks the extent table for add, truncate and read.
// ----------------------------------------------------------------------------
module emoc_ctrl
    import emoc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    t_state      r_state, n_state;
    logic        r_placed, n_placed;
    logic [1:0]  r_phase, n_phase;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_placed <= 1'b0;
            r_phase  <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_placed <= n_placed;
            r_phase  <= n_phase;
        end
    end

    always_comb begin
        cmd      = '0;
        cmd.item = IT_OLD;
        n_state  = r_state;
        n_placed = r_placed;
        n_phase  = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    n_placed  = 1'b0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.req)
                    REQ_ADD:   n_state = i_sts.rev ? S_OUT : S_ARD;
                    REQ_TRUNC: begin
                        if (i_sts.size_zero) begin
                            cmd.t_clear = 1'b1;
                            n_state     = S_OUT;
                        end else begin
                            n_state = S_TRD;
                        end
                    end
                    REQ_READ:  n_state = i_sts.rlen_zero ? S_OUT : S_RRD;
                    default:   n_state = S_OUT;
                endcase
            end
            S_ARD: begin
                if (i_sts.i_eq_used) begin
                    n_state = S_AFIN;
                end else begin
                    cmd.rd_cur = 1'b1;
                    n_phase    = 2'd0;
                    n_state    = S_AEV;
                end
            end
            S_AEV: begin
                if (i_sts.o_lt_new) begin
                    cmd.push  = 1'b1;
                    cmd.item  = IT_OLD;
                    cmd.i_inc = 1'b1;
                    n_state   = S_ARD;
                end else if (i_sts.o_gt_new) begin
                    cmd.push = 1'b1;
                    if (!r_placed) begin
                        cmd.item = IT_NEW;
                        n_placed = 1'b1;
                    end else begin
                        cmd.item  = IT_OLD;
                        cmd.i_inc = 1'b1;
                        n_state   = S_ARD;
                    end
                end else begin
                    case (r_phase)
                        2'd0: begin
                            cmd.push = i_sts.o_s_lt_n;
                            cmd.item = IT_LEFT;
                            n_phase  = 2'd1;
                        end
                        2'd1: begin
                            cmd.push = !r_placed;
                            cmd.item = IT_NEW;
                            n_placed = 1'b1;
                            n_phase  = 2'd2;
                        end
                        default: begin
                            cmd.push  = i_sts.o_e_gt_n;
                            cmd.item  = IT_RIGHT;
                            cmd.i_inc = 1'b1;
                            n_state   = S_ARD;
                        end
                    endcase
                end
            end
            S_AFIN: begin
                if (!r_placed) begin
                    cmd.push = 1'b1;
                    cmd.item = IT_NEW;
                    n_placed = 1'b1;
                end else begin
                    cmd.flush = 1'b1;
                    n_state   = S_ACOM;
                end
            end
            S_ACOM: begin
                cmd.commit = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                cmd.emit_simple = 1'b1;
                n_state         = S_IDLE;
            end
            S_TRD: begin
                if (i_sts.used_zero) begin
                    cmd.t_zeromax = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    cmd.rd_top = 1'b1;
                    n_state    = S_TEV;
                end
            end
            S_TEV: begin
                if (!i_sts.t_e_ge) begin
                    cmd.t_setmax = 1'b1;
                    n_state      = S_OUT;
                end else if (i_sts.t_s_ge) begin
                    cmd.t_dec = 1'b1;
                    n_state   = S_TRD;
                end else begin
                    cmd.t_trim = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_RRD: begin
                if (i_sts.i_eq_used) begin
                    cmd.emit_simple = !i_sts.found;
                    cmd.emit_chunk  = i_sts.found;
                    cmd.chunk_last  = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    cmd.rd_cur = 1'b1;
                    n_state    = S_REV;
                end
            end
            S_REV: begin
                if (!i_sts.found) begin
                    if (i_sts.r_e_lt_rs) begin
                        cmd.i_inc = 1'b1;
                        n_state   = S_RRD;
                    end else if (i_sts.r_s_gt_rend) begin
                        cmd.emit_simple = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        cmd.take  = 1'b1;
                        cmd.i_inc = 1'b1;
                        n_state   = S_RRD;
                    end
                end else if (!i_sts.r_s_gt_rend) begin
                    cmd.emit_chunk = 1'b1;
                    cmd.take       = 1'b1;
                    cmd.i_inc      = 1'b1;
                    n_state        = S_RRD;
                end else begin
                    cmd.emit_chunk = 1'b1;
                    cmd.chunk_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
endmodule

[src/emoc_dp.sv]
// ----------------------------------------------------------------------------
// emoc_dp
// Datapath: ping-pong extent table, merge holding stage, chunk trimming.
// ----------------------------------------------------------------------------
module emoc_dp
    import emoc_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [1:0]             i_req_type,
    input  logic [OFFSET_BITS-1:0] i_range_start,
    input  logic [OFFSET_BITS-1:0] i_range_end,
    input  logic [OFFSET_BITS-1:0] i_read_length,
    input  logic [OFFSET_BITS-1:0] i_truncate_size,
    input  logic [OFFSET_BITS-1:0] i_log_position,
    input  logic [ID_W-1:0]        i_server_rank,
    input  logic [ID_W-1:0]        i_application_id,
    input  logic [ID_W-1:0]        i_client_id,
    output logic                   o_valid,
    output logic                   o_status,
    output logic                   o_chunk_valid,
    output logic [OFFSET_BITS-1:0] o_chunk_offset,
    output logic [OFFSET_BITS-1:0] o_chunk_bytes,
    output logic [OFFSET_BITS-1:0] o_chunk_log_offset,
    output logic [ID_W-1:0]        o_chunk_rank,
    output logic [ID_W-1:0]        o_chunk_app,
    output logic [ID_W-1:0]        o_chunk_client,
    output logic                   o_covered,
    output logic                   o_last,
    output logic [CNT_OUT_W-1:0]   o_extent_count,
    output logic [OFFSET_BITS-1:0] o_max_end
);
    localparam int OB  = OFFSET_BITS;
    localparam int IW  = $clog2(MAX_EXTENTS);
    localparam int CW  = $clog2(MAX_EXTENTS + 1);
    localparam int WCW = $clog2(MAX_EXTENTS + 3);
    localparam int AW  = $clog2(2 * MAX_EXTENTS);

    typedef struct packed {
        logic [OB-1:0]   s;
        logic [OB-1:0]   e;
        logic [OB-1:0]   lp;
        logic [ID_W-1:0] rank;
        logic [ID_W-1:0] app;
        logic [ID_W-1:0] cli;
    } t_ent;
    localparam int EW = $bits(t_ent);

    logic [1:0]     r_type;
    logic [OB-1:0]  r_rs, r_rlen, r_tsize, r_rend;
    t_ent           r_new, r_pend, r_h;
    logic           r_hvld, r_hnew;
    logic [CW-1:0]  r_i, r_used;
    logic [WCW-1:0] r_wcnt;
    logic           r_bank, r_status, r_found, r_gap, r_rev;
    logic [OB-1:0]  r_max;

    logic           r_valid, r_st, r_cv, r_cov, r_last;
    logic [OB-1:0]  r_coff, r_cbytes, r_clp;
    logic [ID_W-1:0] r_crank, r_capp, r_ccli;
    logic [CNT_OUT_W-1:0] r_cnt;
    logic [OB-1:0]  r_omax;

    logic [EW-1:0]  rdata, wdata;
    t_ent           o_ent, x_ent, trim_ent;
    logic           we, re, x_new, merge, can, wr_room, full;
    logic [AW-1:0]  raddr, waddr, base_cur, base_oth;
    logic [CW-1:0]  used_m1;
    logic [IW-1:0]  ridx;
    logic [OB:0]    rend_sum;
    logic [OB-1:0]  h_lp_next, p_off, p_lp, p_top;

    assign o_ent    = t_ent'(rdata);
    assign used_m1  = r_used - CW'(1);
    assign base_cur = r_bank ? AW'(MAX_EXTENTS) : '0;
    assign base_oth = r_bank ? '0 : AW'(MAX_EXTENTS);
    assign ridx     = i_cmd.rd_top ? used_m1[IW-1:0] : r_i[IW-1:0];
    assign raddr    = base_cur + AW'(ridx);
    assign re       = i_cmd.rd_cur | i_cmd.rd_top;
    assign wr_room  = r_wcnt < WCW'(MAX_EXTENTS);
    assign full     = r_wcnt > WCW'(MAX_EXTENTS);

    always_comb begin
        x_ent = o_ent;
        case (i_cmd.item)
            IT_OLD:  x_ent = o_ent;
            IT_LEFT: x_ent.e = r_new.s - OB'(1);
            IT_NEW:  x_ent = r_new;
            default: begin
                x_ent.s  = r_new.e + OB'(1);
                x_ent.lp = o_ent.lp + (r_new.e + OB'(1) - o_ent.s);
            end
        endcase
    end
    assign x_new     = (i_cmd.item == IT_NEW);
    assign h_lp_next = r_h.lp + (r_h.e - r_h.s) + OB'(1);
    assign can = ((OB+1)'(r_h.e) + (OB+1)'(1) == (OB+1)'(x_ent.s)) &&
                 (r_h.rank == x_ent.rank) && (r_h.app == x_ent.app) &&
                 (r_h.cli == x_ent.cli) && (h_lp_next == x_ent.lp);
    assign merge = r_hvld && (r_hnew || x_new) && can;

    always_comb begin
        trim_ent   = o_ent;
        trim_ent.e = r_tsize - OB'(1);
    end

    assign we = i_cmd.t_trim ||
                (r_hvld && wr_room && ((i_cmd.push && !merge) || i_cmd.flush));
    assign waddr = i_cmd.t_trim ? base_cur + AW'(used_m1[IW-1:0])
                                : base_oth + AW'(r_wcnt[IW-1:0]);
    assign wdata = i_cmd.t_trim ? EW'(trim_ent) : EW'(r_h);

    emoc_ram #(
        .W (EW),
        .D (2 * MAX_EXTENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rend_sum = (OB+1)'(i_range_start) + (OB+1)'(i_read_length) - (OB+1)'(1);

    // chunk trimming against the read range
    assign p_off = (r_pend.s < r_rs) ? r_rs : r_pend.s;
    assign p_lp  = (r_pend.s < r_rs) ? r_pend.lp + (r_rs - r_pend.s) : r_pend.lp;
    assign p_top = (r_pend.e > r_rend) ? r_rend : r_pend.e;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_type    <= i_req_type;
            r_rs      <= i_range_start;
            r_rlen    <= i_read_length;
            r_tsize   <= i_truncate_size;
            r_rend    <= rend_sum[OB] ? '1 : rend_sum[OB-1:0];
            r_rev     <= i_range_end < i_range_start;
            r_new.s   <= i_range_start;
            r_new.e   <= i_range_end;
            r_new.lp  <= i_log_position;
            r_new.rank <= i_server_rank;
            r_new.app <= i_application_id;
            r_new.cli <= i_client_id;
        end
        if (i_cmd.push) begin
            if (merge) begin
                r_h.e <= x_ent.e;
            end else begin
                r_h <= x_ent;
            end
            r_hnew <= x_new;
        end
        if (i_cmd.take) begin
            r_pend <= o_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_used   <= '0;
            r_wcnt   <= '0;
            r_bank   <= 1'b0;
            r_status <= 1'b0;
            r_found  <= 1'b0;
            r_gap    <= 1'b0;
            r_hvld   <= 1'b0;
            r_max    <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_i      <= '0;
                r_wcnt   <= '0;
                r_status <= 1'b0;
                r_found  <= 1'b0;
                r_gap    <= 1'b0;
                r_hvld   <= 1'b0;
            end
            if (i_cmd.i_inc) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.push) begin
                r_hvld <= 1'b1;
                if (r_hvld && !merge) begin
                    r_wcnt <= r_wcnt + WCW'(1);
                end
            end
            if (i_cmd.flush && r_hvld) begin
                r_wcnt <= r_wcnt + WCW'(1);
                r_hvld <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_status <= full;
                if (!full) begin
                    r_bank <= !r_bank;
                    r_used <= CW'(r_wcnt);
                    if (r_new.e > r_max) begin
                        r_max <= r_new.e;
                    end
                end
            end
            if (i_cmd.t_clear) begin
                r_used <= '0;
                r_max  <= '0;
            end
            if (i_cmd.t_zeromax) begin
                r_max <= '0;
            end
            if (i_cmd.t_setmax) begin
                r_max <= o_ent.e;
            end
            if (i_cmd.t_dec) begin
                r_used <= used_m1;
            end
            if (i_cmd.t_trim) begin
                r_max <= r_tsize - OB'(1);
            end
            if (i_cmd.take) begin
                r_found <= 1'b1;
                if (!r_found) begin
                    r_gap <= o_ent.s > r_rs;
                end else if ((OB+1)'(r_pend.e) + (OB+1)'(1) != (OB+1)'(o_ent.s)) begin
                    r_gap <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_simple | i_cmd.emit_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= CNT_OUT_W'(r_used);
        r_omax <= r_max;
        if (i_cmd.emit_chunk) begin
            r_st     <= 1'b0;
            r_cv     <= 1'b1;
            r_coff   <= p_off;
            r_cbytes <= p_top - p_off + OB'(1);
            r_clp    <= p_lp;
            r_crank  <= r_pend.rank;
            r_capp   <= r_pend.app;
            r_ccli   <= r_pend.cli;
            r_cov    <= i_cmd.chunk_last && !r_gap && (r_pend.e >= r_rend);
            r_last   <= i_cmd.chunk_last;
        end else begin
            r_st     <= r_status;
            r_cv     <= 1'b0;
            r_coff   <= '0;
            r_cbytes <= '0;
            r_clp    <= '0;
            r_crank  <= '0;
            r_capp   <= '0;
            r_ccli   <= '0;
            r_cov    <= 1'b0;
            r_last   <= 1'b1;
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.req         = t_req'(r_type);
        o_sts.rev         = r_rev;
        o_sts.size_zero   = (r_tsize == '0);
        o_sts.rlen_zero   = (r_rlen == '0);
        o_sts.i_eq_used   = (r_i == r_used);
        o_sts.used_zero   = (r_used == '0);
        o_sts.found       = r_found;
        o_sts.o_lt_new    = o_ent.e < r_new.s;
        o_sts.o_gt_new    = o_ent.s > r_new.e;
        o_sts.o_s_lt_n    = o_ent.s < r_new.s;
        o_sts.o_e_gt_n    = o_ent.e > r_new.e;
        o_sts.t_e_ge      = o_ent.e >= r_tsize;
        o_sts.t_s_ge      = o_ent.s >= r_tsize;
        o_sts.r_e_lt_rs   = o_ent.e < r_rs;
        o_sts.r_s_gt_rend = o_ent.s > r_rend;
    end

    assign o_valid            = r_valid;
    assign o_status           = r_st;
    assign o_chunk_valid      = r_cv;
    assign o_chunk_offset     = r_coff;
    assign o_chunk_bytes      = r_cbytes;
    assign o_chunk_log_offset = r_clp;
    assign o_chunk_rank       = r_crank;
    assign o_chunk_app        = r_capp;
    assign o_chunk_client     = r_ccli;
    assign o_covered          = r_cov;
    assign o_last             = r_last;
    assign o_extent_count     = r_cnt;
    assign o_max_end          = r_omax;
endmodule

[src/extent_map_overwrite_coalesce_top.sv]
// ----------------------------------------------------------------------------
// extent_map_overwrite_coalesce_top
// Each request walks the table with one table RAM read per entry visited.
// One request at a time; each result strobe lasts one cycle, no stall.
// Synchronous active-low reset empties the table; no clearing pass.
// ----------------------------------------------------------------------------
module extent_map_overwrite_coalesce_top
    import emoc_pkg::*;
#(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_req_type,
    input  logic [OFFSET_BITS-1:0] i_range_start,
    input  logic [OFFSET_BITS-1:0] i_range_end,
    input  logic [OFFSET_BITS-1:0] i_read_length,
    input  logic [OFFSET_BITS-1:0] i_truncate_size,
    input  logic [OFFSET_BITS-1:0] i_log_position,
    input  logic [ID_W-1:0]        i_server_rank,
    input  logic [ID_W-1:0]        i_application_id,
    input  logic [ID_W-1:0]        i_client_id,
    output logic                   o_valid,
    output logic                   o_status,
    output logic                   o_chunk_valid,
    output logic [OFFSET_BITS-1:0] o_chunk_offset,
    output logic [OFFSET_BITS-1:0] o_chunk_bytes,
    output logic [OFFSET_BITS-1:0] o_chunk_log_offset,
    output logic [ID_W-1:0]        o_chunk_rank,
    output logic [ID_W-1:0]        o_chunk_app,
    output logic [ID_W-1:0]        o_chunk_client,
    output logic                   o_covered,
    output logic                   o_last,
    output logic [CNT_OUT_W-1:0]   o_extent_count,
    output logic [OFFSET_BITS-1:0] o_max_end
);
    t_cmd cmd;
    t_sts sts;

    emoc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    emoc_dp #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_req_type         (i_req_type),
        .i_range_start      (i_range_start),
        .i_range_end        (i_range_end),
        .i_read_length      (i_read_length),
        .i_truncate_size    (i_truncate_size),
        .i_log_position     (i_log_position),
        .i_server_rank      (i_server_rank),
        .i_application_id   (i_application_id),
        .i_client_id        (i_client_id),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_chunk_valid      (o_chunk_valid),
        .o_chunk_offset     (o_chunk_offset),
        .o_chunk_bytes      (o_chunk_bytes),
        .o_chunk_log_offset (o_chunk_log_offset),
        .o_chunk_rank       (o_chunk_rank),
        .o_chunk_app        (o_chunk_app),
        .o_chunk_client     (o_chunk_client),
        .o_covered          (o_covered),
        .o_last             (o_last),
        .o_extent_count     (o_extent_count),
        .o_max_end          (o_max_end)
    );

`ifndef SYNTHESIS
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without request");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request not taken");
    a_full_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && !o_chunk_valid) else $error("bad full result");
    a_cover_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_covered |-> o_last && o_chunk_valid) else $error("bad covered");
`endif
endmodule
